### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the delta index list encoder.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

### hw/rtl/dile_pkg.sv
// Shared types and constants of the delta index list encoder.
// Used by the front end, the packet queue, the byte serializer and the top level.
package dile_pkg;

	localparam int PKT_BYTES = 6;
	localparam int PKT_W = 8 * PKT_BYTES;
	localparam int LEN_W = 3;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] ACT_KEY  = 2'd0;
	localparam logic [1:0] ACT_HEAD = 2'd1;
	localparam logic [1:0] ACT_NEXT = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [15:0] COUNT_TAG  = 16'hF000;
	localparam logic [31:0] FIT14_MASK = 32'hFFFF_C000;
	localparam logic [15:0] TAG14      = 16'h8000;
	localparam logic [31:0] FIT23_MASK = 32'hFF80_0000;
	localparam logic [1:0]  TAG30      = 2'b11;

	localparam logic [LEN_W-1:0] LEN_KEY  = 3'd1;
	localparam logic [LEN_W-1:0] LEN_HEAD = 3'd6;
	localparam logic [LEN_W-1:0] LEN_D14  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_D23  = 3'd3;
	localparam logic [LEN_W-1:0] LEN_D30  = 3'd4;

	// One classified item: bytes to send, least significant first.
	typedef struct packed {
		logic [PKT_W-1:0] data;
		logic [LEN_W-1:0] len;
		logic             wide;
	} pkt_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

### hw/rtl/delta_index_list_encoder.sv
// Top level of the delta index list encoder: front end, packet queue, serializer.
// Depends on dile_pkg, dile_front, dile_queue, dile_back and assert_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | action, name_byte, list_count, index_value
//  out     | out_valid / out_ready| out_byte, last_byte, delta_too_wide
//
// The output sends one byte per cycle while out_ready is high; an item has 1
// byte for a key, 2 to 4 bytes for a next index and 6 bytes for a header.
// The input takes one item per cycle while the packet queue has room.
// Reset clears the previous index to zero and empties the queue and serializer.
// Either side may stall; the queue lets the front end run ahead of the output.
`include "assert_macros.svh"
module delta_index_list_encoder #(
	parameter int QUEUE_DEPTH = dile_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  name_byte,
	input  logic [11:0] list_count,
	input  logic [31:0] index_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic        delta_too_wide
);
	import dile_pkg::*;

	pkt_t    wr_pkt;
	pkt_t    rd_pkt;
	q_stat_t q_stat;
	logic    push;
	logic    pop;
	logic    drain_beat;
	logic    wide_tag_bad;

	dile_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.name_byte   (name_byte),
		.list_count  (list_count),
		.index_value (index_value),
		.q_stat      (q_stat),
		.push        (push),
		.pkt         (wr_pkt)
	);

	dile_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_pkt (wr_pkt),
		.pop    (pop),
		.rd_pkt (rd_pkt),
		.stat   (q_stat)
	);

	dile_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_pkt          (rd_pkt),
		.q_stat         (q_stat),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last_byte      (last_byte),
		.delta_too_wide (delta_too_wide)
	);

	assign drain_beat   = out_valid && out_ready && last_byte && !q_stat.not_empty;
	assign wide_tag_bad = out_valid && delta_too_wide && last_byte
		&& (out_byte[7:6] != TAG30);

	// A packet keeps the output busy until its final byte.
	`ASSERT_CLK(a_burst_continues, clk, arst_n, out_valid && !last_byte |=> out_valid)
	// With nothing queued, the final byte leaving leaves the output idle.
	`ASSERT_CLK(a_drain_idle, clk, arst_n, drain_beat |=> !out_valid)
	// A flagged delta always closes with the long tag in its top byte.
	`ASSERT_NEVER(a_wide_tag, clk, arst_n, wide_tag_bad)

endmodule

### hw/rtl/dile_front.sv
// Front end: accepts input items, forms the delta and packs each item's bytes.
// Depends on dile_pkg.
module dile_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             action,
	input  logic [7:0]             name_byte,
	input  logic [11:0]            list_count,
	input  logic [31:0]            index_value,
	input  dile_pkg::q_stat_t      q_stat,
	output logic                   push,
	output dile_pkg::pkt_t         pkt
);
	import dile_pkg::*;

	logic [31:0] prev_index_q;
	logic [31:0] delta;
	logic        accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (action != ACT_NONE);
	assign delta    = index_value - prev_index_q;

	always_comb begin
		pkt = '0;
		case (action)
			ACT_KEY: begin
				pkt.data = {{(PKT_W-8){1'b0}}, name_byte};
				pkt.len  = LEN_KEY;
			end
			ACT_HEAD: begin
				pkt.data = {index_value, COUNT_TAG | {4'b0, list_count}};
				pkt.len  = LEN_HEAD;
			end
			ACT_NEXT: begin
				if ((delta & FIT14_MASK) == 32'd0) begin
					pkt.data = {{(PKT_W-16){1'b0}}, TAG14 | delta[15:0]};
					pkt.len  = LEN_D14;
				end else if ((delta & FIT23_MASK) == 32'd0) begin
					pkt.data = {{(PKT_W-24){1'b0}}, delta[23:0]};
					pkt.len  = LEN_D23;
				end else begin
					// Bits 31..30 are dropped under the long tag and flagged.
					pkt.data = {{(PKT_W-32){1'b0}}, TAG30, delta[29:0]};
					pkt.len  = LEN_D30;
					pkt.wide = |delta[31:30];
				end
			end
			default: begin
				pkt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_index_q <= '0;
		end else if (accept && (action == ACT_HEAD || action == ACT_NEXT)) begin
			prev_index_q <= index_value;
		end
	end

endmodule

### hw/rtl/dile_queue.sv
// Small packet queue between the front end and the byte serializer.
// Depends on dile_pkg.
module dile_queue #(
	parameter int DEPTH = dile_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dile_pkg::pkt_t    wr_pkt,
	input  logic              pop,
	output dile_pkg::pkt_t    rd_pkt,
	output dile_pkg::q_stat_t stat
);
	import dile_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pkt_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rd_pkt         = slot_q[rd_ptr_q];
	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/dile_back.sv
// Byte serializer: takes packets from the queue and sends one byte per beat.
// Depends on dile_pkg.
module dile_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dile_pkg::pkt_t        q_pkt,
	input  dile_pkg::q_stat_t     q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  last_byte,
	output logic                  delta_too_wide
);
	import dile_pkg::*;

	logic [PKT_W-1:0] data_q;
	logic [LEN_W-1:0] rem_q;
	logic             wide_q;

	assign out_valid      = (rem_q != '0);
	assign out_byte       = data_q[7:0];
	assign last_byte      = (rem_q == LEN_W'(1));
	assign delta_too_wide = wide_q;

	// The next packet loads while the last byte of the current one leaves.
	assign pop = q_stat.not_empty && (!out_valid || (out_ready && last_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (pop) begin
			rem_q <= q_pkt.len;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_pkt.data;
			wide_q <= q_pkt.wide;
		end else if (out_valid && out_ready) begin
			data_q <= data_q >> 8;
		end
	end

endmodule
